>>> rtl/rraf_pkg.sv
`timescale 1ns / 1ps

package rraf_pkg;

    localparam int FB_COLS_DEF = 1024;
    localparam int FB_ROWS_DEF = 768;

    localparam int COORD_W  = 13;
    localparam int SIZE_W   = 13;
    localparam int RADIUS_W = 12;
    localparam int OFS_W    = 12;
    localparam int PIX_W    = 32;
    localparam int ALPHA_W  = 8;
    localparam int CHAN_W   = 8;
    localparam int ADDR_W   = 20;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECT_X        = 3'd0,
        CFG_RECT_Y        = 3'd1,
        CFG_RECT_WIDTH    = 3'd2,
        CFG_RECT_HEIGHT   = 3'd3,
        CFG_CORNER_RADIUS = 3'd4,
        CFG_FILL_COLOR    = 3'd5,
        CFG_FILL_ALPHA    = 3'd6
    } cfg_idx_t;

endpackage

>>> rtl/rraf_blend.sv
`timescale 1ns / 1ps

module rraf_blend (
    input  logic                        aclk,
    input  logic                        ce,
    input  logic [rraf_pkg::CHAN_W-1:0] fg,
    input  logic [rraf_pkg::CHAN_W-1:0] bg,
    input  logic [rraf_pkg::CHAN_W-1:0] alpha,
    output logic [rraf_pkg::CHAN_W-1:0] result
);
    import rraf_pkg::*;

    localparam int PROD_W = 2 * CHAN_W;

    logic [CHAN_W-1:0] inv_alpha;
    logic [PROD_W-1:0] prod_fg_reg;
    logic [PROD_W-1:0] prod_bg_reg;
    logic [PROD_W-1:0] sum_reg;
    logic [PROD_W-1:0] sum_next;
    logic [PROD_W:0]   quo_tmp;

    assign inv_alpha = ALPHA_OPAQUE - alpha;
    assign sum_next  = prod_fg_reg + prod_bg_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_fg_reg <= PROD_W'(fg) * PROD_W'(alpha);
            prod_bg_reg <= PROD_W'(bg) * PROD_W'(inv_alpha);
            sum_reg     <= sum_next;
        end
    end

    // x / 255 for x <= 255*255: (x + 1 + (x >> 8)) >> 8
    assign quo_tmp = (PROD_W+1)'(sum_reg) + (PROD_W+1)'(1)
                   + (PROD_W+1)'(sum_reg[PROD_W-1:CHAN_W]);
    assign result  = quo_tmp[PROD_W-1:CHAN_W];

endmodule

>>> rtl/rounded_rect_alpha_fill_top.sv
`timescale 1ns / 1ps
// Rounded-rectangle fill with alpha blend, one pixel item per clock.
// Five register stages; the valid bit passes s1, s2, s3 and s4 on to m_valid.
// Throughput: one item per cycle; a stall on m_ready freezes all five stages.
// s_ready follows the output register (ready when it is empty or being drained).
// Reset (aresetn, sync, low) clears all stage valids and returns config to defaults.

module rounded_rect_alpha_fill_top #(
    parameter int FB_COLS = rraf_pkg::FB_COLS_DEF,
    parameter int FB_ROWS = rraf_pkg::FB_ROWS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rraf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rraf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rraf_pkg::OFS_W-1:0]     s_offset_col,
    input  logic [rraf_pkg::OFS_W-1:0]     s_offset_row,
    input  logic [rraf_pkg::PIX_W-1:0]     s_background_pixel,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_write_enable,
    output logic [rraf_pkg::ADDR_W-1:0]    m_pixel_address,
    output logic [rraf_pkg::PIX_W-1:0]     m_pixel_value
);
    import rraf_pkg::*;

    localparam int SW_W  = 13;
    localparam int D_W   = 15;
    localparam int P_W   = 14;
    localparam int AB_W  = 13;
    localparam int SQ_W  = 2 * AB_W;
    localparam int RR_W  = 2 * RADIUS_W;
    localparam int FA_W  = 25;
    localparam logic [SW_W-1:0] SW = SW_W'(FB_COLS);
    localparam logic [SW_W-1:0] SH = SW_W'(FB_ROWS);

    // configuration
    logic signed [COORD_W-1:0] rect_x_reg;
    logic signed [COORD_W-1:0] rect_y_reg;
    logic [SIZE_W-1:0]         rect_width_reg;
    logic [SIZE_W-1:0]         rect_height_reg;
    logic [RADIUS_W-1:0]       corner_radius_reg;
    logic [PIX_W-1:0]          fill_color_reg;
    logic [ALPHA_W-1:0]        fill_alpha_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rect_x_reg        <= '0;
            rect_y_reg        <= '0;
            rect_width_reg    <= '0;
            rect_height_reg   <= '0;
            corner_radius_reg <= '0;
            fill_color_reg    <= '0;
            fill_alpha_reg    <= ALPHA_OPAQUE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RECT_X:        rect_x_reg        <= cfg_data[COORD_W-1:0];
                CFG_RECT_Y:        rect_y_reg        <= cfg_data[COORD_W-1:0];
                CFG_RECT_WIDTH:    rect_width_reg    <= cfg_data[SIZE_W-1:0];
                CFG_RECT_HEIGHT:   rect_height_reg   <= cfg_data[SIZE_W-1:0];
                CFG_CORNER_RADIUS: corner_radius_reg <= cfg_data[RADIUS_W-1:0];
                CFG_FILL_COLOR:    fill_color_reg    <= cfg_data[PIX_W-1:0];
                CFG_FILL_ALPHA:    fill_alpha_reg    <= cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    logic ce;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, m_valid_reg;

    assign ce      = !m_valid_reg || m_ready;
    assign s_ready = ce;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (ce) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            m_valid_reg  <= s4_valid_reg;
        end
    end

    // stage 1: input item
    logic [OFS_W-1:0] s1_col_reg, s1_row_reg;
    logic [PIX_W-1:0] s1_bg_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_col_reg <= s_offset_col;
            s1_row_reg <= s_offset_row;
            s1_bg_reg  <= s_background_pixel;
        end
    end

    // stage 2: corner region, distances, bounds
    logic signed [D_W-1:0] r_s, dx_s, dy_s, right_s, bottom_s;
    logic signed [D_W-1:0] a_lo, a_hi, b_lo, b_hi;
    logic                  x_lo, x_hi, y_lo, y_hi;
    logic [AB_W-1:0]       a_next, b_next;
    logic                  corner_next, keep_next;
    logic signed [P_W-1:0] px, py;
    logic                  inrect, onscreen;

    always_comb begin
        r_s      = $signed(D_W'(corner_radius_reg));
        dx_s     = $signed(D_W'(s1_col_reg));
        dy_s     = $signed(D_W'(s1_row_reg));
        right_s  = $signed(D_W'(rect_width_reg)) - r_s - D_W'(1);
        bottom_s = $signed(D_W'(rect_height_reg)) - r_s - D_W'(1);
        x_lo     = dx_s < r_s;
        x_hi     = dx_s > right_s;
        y_lo     = dy_s < r_s;
        y_hi     = dy_s > bottom_s;
        a_lo     = r_s - dx_s;
        a_hi     = dx_s - right_s;
        b_lo     = r_s - dy_s;
        b_hi     = dy_s - bottom_s;
        corner_next = 1'b1;
        a_next      = a_lo[AB_W-1:0];
        b_next      = b_lo[AB_W-1:0];
        if (x_lo && y_lo) begin
            a_next = a_lo[AB_W-1:0];
            b_next = b_lo[AB_W-1:0];
        end else if (x_hi && y_lo) begin
            a_next = a_hi[AB_W-1:0];
            b_next = b_lo[AB_W-1:0];
        end else if (x_lo && y_hi) begin
            a_next = a_lo[AB_W-1:0];
            b_next = b_hi[AB_W-1:0];
        end else if (x_hi && y_hi) begin
            a_next = a_hi[AB_W-1:0];
            b_next = b_hi[AB_W-1:0];
        end else begin
            corner_next = 1'b0;
        end

        px = $signed({rect_x_reg[COORD_W-1], rect_x_reg}) + $signed(P_W'(s1_col_reg));
        py = $signed({rect_y_reg[COORD_W-1], rect_y_reg}) + $signed(P_W'(s1_row_reg));
        inrect   = (SIZE_W'(s1_col_reg) < rect_width_reg)
                && (SIZE_W'(s1_row_reg) < rect_height_reg);
        onscreen = !px[P_W-1] && (px[SW_W-1:0] < SW)
                && !py[P_W-1] && (py[SW_W-1:0] < SH);
        keep_next = inrect && onscreen && (fill_alpha_reg != ALPHA_CLEAR);
    end

    logic [AB_W-1:0]  s2_a_reg, s2_b_reg;
    logic             s2_corner_reg, s2_keep_reg;
    logic [OFS_W-1:0] s2_px_reg, s2_py_reg;
    logic [PIX_W-1:0] s2_bg_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s2_a_reg      <= a_next;
            s2_b_reg      <= b_next;
            s2_corner_reg <= corner_next;
            s2_keep_reg   <= keep_next;
            s2_px_reg     <= px[OFS_W-1:0];
            s2_py_reg     <= py[OFS_W-1:0];
            s2_bg_reg     <= s1_bg_reg;
        end
    end

    // stage 3: squares
    logic [SQ_W-1:0]  s3_aa_reg, s3_bb_reg;
    logic [RR_W-1:0]  s3_rr_reg;
    logic             s3_corner_reg, s3_keep_reg;
    logic [OFS_W-1:0] s3_px_reg, s3_py_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s3_aa_reg     <= SQ_W'(s2_a_reg) * SQ_W'(s2_a_reg);
            s3_bb_reg     <= SQ_W'(s2_b_reg) * SQ_W'(s2_b_reg);
            s3_rr_reg     <= RR_W'(corner_radius_reg) * RR_W'(corner_radius_reg);
            s3_corner_reg <= s2_corner_reg;
            s3_keep_reg   <= s2_keep_reg;
            s3_px_reg     <= s2_px_reg;
            s3_py_reg     <= s2_py_reg;
        end
    end

    // stage 4: circle test and address
    logic [SQ_W:0]       dist_sum;
    logic                we_next;
    logic [FA_W-1:0]     addr_full;
    logic                s4_we_reg;
    logic [ADDR_W-1:0]   s4_addr_reg;

    assign dist_sum  = (SQ_W+1)'(s3_aa_reg) + (SQ_W+1)'(s3_bb_reg);
    assign we_next   = s3_keep_reg && (!s3_corner_reg || (dist_sum <= (SQ_W+1)'(s3_rr_reg)));
    assign addr_full = FA_W'(s3_py_reg) * FA_W'(SW) + FA_W'(s3_px_reg);

    always_ff @(posedge aclk) begin
        if (ce) begin
            s4_we_reg   <= we_next;
            s4_addr_reg <= addr_full[ADDR_W-1:0];
        end
    end

    // blend channels, stages 3 and 4
    logic [CHAN_W-1:0] blend_ch [3];

    for (genvar g = 0; g < 3; g++) begin : g_chan
        rraf_blend u_blend (
            .aclk   (aclk),
            .ce     (ce),
            .fg     (fill_color_reg[g*CHAN_W +: CHAN_W]),
            .bg     (s2_bg_reg[g*CHAN_W +: CHAN_W]),
            .alpha  (fill_alpha_reg),
            .result (blend_ch[g])
        );
    end

    // stage 5: output register
    logic [PIX_W-1:0]  value_next;
    logic              m_we_reg;
    logic [ADDR_W-1:0] m_addr_reg;
    logic [PIX_W-1:0]  m_value_reg;

    always_comb begin
        if (fill_alpha_reg == ALPHA_OPAQUE) begin
            value_next = fill_color_reg;
        end else begin
            value_next = {CHAN_W'(0), blend_ch[2], blend_ch[1], blend_ch[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_we_reg    <= s4_we_reg;
            m_addr_reg  <= s4_we_reg ? s4_addr_reg : '0;
            m_value_reg <= s4_we_reg ? value_next : '0;
        end
    end

    assign m_write_enable  = m_we_reg;
    assign m_pixel_address = m_addr_reg;
    assign m_pixel_value   = m_value_reg;

endmodule

>>> dv/rraf_fill_checker.sv
`timescale 1ns / 1ps

module rraf_fill_checker
    import rraf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [OFS_W-1:0]     s_offset_col,
    input  logic [OFS_W-1:0]     s_offset_row,
    input  logic [PIX_W-1:0]     s_background_pixel,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_write_enable,
    input  logic [ADDR_W-1:0]    m_pixel_address,
    input  logic [PIX_W-1:0]     m_pixel_value,
    output int                   fail_count,
    output int                   pending_count,
    output int                   results_checked,
    output int                   pixels_written
);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  value;
    } pixel_write_t;

    longint             org_x;
    longint             org_y;
    longint             box_w;
    longint             box_h;
    longint             radius;
    logic [PIX_W-1:0]   color;
    logic [ALPHA_W-1:0] alpha;

    pixel_write_t expected_pixels[$];

    initial begin
        fail_count      = 0;
        pending_count   = 0;
        results_checked = 0;
        pixels_written  = 0;
    end

    // first corner region that holds the offset decides; else inside
    function automatic bit in_rounded_shape(longint dx, longint dy);
        longint right;
        longint bottom;
        longint a;
        longint b;
        right  = box_w - radius - 1;
        bottom = box_h - radius - 1;
        if (dx < radius && dy < radius) begin
            a = radius - dx;
            b = radius - dy;
        end else if (dx > right && dy < radius) begin
            a = dx - right;
            b = radius - dy;
        end else if (dx < radius && dy > bottom) begin
            a = radius - dx;
            b = dy - bottom;
        end else if (dx > right && dy > bottom) begin
            a = dx - right;
            b = dy - bottom;
        end else begin
            return 1'b1;
        end
        return (a * a + b * b) <= radius * radius;
    endfunction

    function automatic logic [CHAN_W-1:0] mix_channel(logic [CHAN_W-1:0] fg,
                                                      logic [CHAN_W-1:0] bg,
                                                      logic [ALPHA_W-1:0] a);
        int opaque;
        int sum;
        opaque = int'(ALPHA_OPAQUE);
        sum    = int'(fg) * int'(a) + int'(bg) * (opaque - int'(a));
        return CHAN_W'(sum / opaque);
    endfunction

    function automatic pixel_write_t predict_fill(logic [OFS_W-1:0] col,
                                                  logic [OFS_W-1:0] row,
                                                  logic [PIX_W-1:0] bg);
        longint       dx;
        longint       dy;
        longint       px;
        longint       py;
        pixel_write_t res;
        dx  = longint'(col);
        dy  = longint'(row);
        px  = org_x + dx;
        py  = org_y + dy;
        res = '0;
        if (dx >= box_w || dy >= box_h) return res;
        if (!in_rounded_shape(dx, dy)) return res;
        if (px < 0 || px >= FB_COLS_DEF || py < 0 || py >= FB_ROWS_DEF) return res;
        if (alpha == ALPHA_CLEAR) return res;
        res.we   = 1'b1;
        res.addr = ADDR_W'(py * FB_COLS_DEF + px);
        if (alpha == ALPHA_OPAQUE) begin
            res.value = color;
        end else begin
            res.value = {8'h00,
                         mix_channel(color[23:16], bg[23:16], alpha),
                         mix_channel(color[15:8],  bg[15:8],  alpha),
                         mix_channel(color[7:0],   bg[7:0],   alpha)};
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [PIX_W-1:0] want,
                                   logic [PIX_W-1:0] got);
        $display("[%0t] %s: expected 0x%0h, got 0x%0h", $realtime, field, want, got);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        pixel_write_t want;
        if (!aresetn) begin
            org_x  = 0;
            org_y  = 0;
            box_w  = 0;
            box_h  = 0;
            radius = 0;
            color  = '0;
            alpha  = ALPHA_OPAQUE;
            expected_pixels.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_RECT_X:        org_x  = longint'($signed(cfg_data[COORD_W-1:0]));
                    CFG_RECT_Y:        org_y  = longint'($signed(cfg_data[COORD_W-1:0]));
                    CFG_RECT_WIDTH:    box_w  = longint'(cfg_data[SIZE_W-1:0]);
                    CFG_RECT_HEIGHT:   box_h  = longint'(cfg_data[SIZE_W-1:0]);
                    CFG_CORNER_RADIUS: radius = longint'(cfg_data[RADIUS_W-1:0]);
                    CFG_FILL_COLOR:    color  = cfg_data[PIX_W-1:0];
                    CFG_FILL_ALPHA:    alpha  = cfg_data[ALPHA_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_pixels.push_back(predict_fill(s_offset_col, s_offset_row,
                                                       s_background_pixel));
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected result", '0, PIX_W'(m_write_enable));
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_write_enable !== want.we)
                        report_mismatch("write_enable", PIX_W'(want.we),
                                        PIX_W'(m_write_enable));
                    if (m_pixel_address !== want.addr)
                        report_mismatch("pixel_address", PIX_W'(want.addr),
                                        PIX_W'(m_pixel_address));
                    if (m_pixel_value !== want.value)
                        report_mismatch("pixel_value", want.value, m_pixel_value);
                    results_checked <= results_checked + 1;
                    if (want.we) pixels_written <= pixels_written + 1;
                end
            end
        end
        pending_count <= expected_pixels.size();
    end

endmodule

>>> dv/rounded_rect_alpha_fill_top_tb.sv
`timescale 1ns / 1ps

module rounded_rect_alpha_fill_top_tb;
    import rraf_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [OFS_W-1:0]     s_offset_col;
    logic [OFS_W-1:0]     s_offset_row;
    logic [PIX_W-1:0]     s_background_pixel;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_write_enable;
    logic [ADDR_W-1:0]    m_pixel_address;
    logic [PIX_W-1:0]     m_pixel_value;

    logic gaps_on;
    int   fail_count;
    int   pending_count;
    int   results_checked;
    int   pixels_written;
    int   settings_used;
    int   idle_cycles;

    rounded_rect_alpha_fill_top u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_offset_col       (s_offset_col),
        .s_offset_row       (s_offset_row),
        .s_background_pixel (s_background_pixel),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_write_enable     (m_write_enable),
        .m_pixel_address    (m_pixel_address),
        .m_pixel_value      (m_pixel_value)
    );

    rraf_fill_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_offset_col       (s_offset_col),
        .s_offset_row       (s_offset_row),
        .s_background_pixel (s_background_pixel),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_write_enable     (m_write_enable),
        .m_pixel_address    (m_pixel_address),
        .m_pixel_value      (m_pixel_value),
        .fail_count         (fail_count),
        .pending_count      (pending_count),
        .results_checked    (results_checked),
        .pixels_written     (pixels_written)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= !gaps_on || ($urandom_range(0, 99) >= 11);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
    endtask

    task automatic apply_setting(int x, int y, int w, int h, int r,
                                 logic [PIX_W-1:0] fill, logic [ALPHA_W-1:0] a);
        write_reg(CFG_RECT_X,        CFG_W'(x));
        write_reg(CFG_RECT_Y,        CFG_W'(y));
        write_reg(CFG_RECT_WIDTH,    CFG_W'(w));
        write_reg(CFG_RECT_HEIGHT,   CFG_W'(h));
        write_reg(CFG_CORNER_RADIUS, CFG_W'(r));
        write_reg(CFG_FILL_COLOR,    fill);
        write_reg(CFG_FILL_ALPHA,    CFG_W'(a));
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic send_pixel(int col, int row, logic [PIX_W-1:0] bg);
        while (gaps_on && $urandom_range(0, 99) < 11) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_offset_col       <= OFS_W'(col);
        s_offset_row       <= OFS_W'(row);
        s_background_pixel <= bg;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drain the pipe before touching the registers again
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_random_phase(int count);
        int x, y, w, h, r, a, sel, col, row;
        sel = $urandom_range(0, 9);
        x = (sel < 8) ? $urandom_range(0, 1100) - 60 : int'($signed(13'($urandom())));
        sel = $urandom_range(0, 9);
        y = (sel < 8) ? $urandom_range(0, 840) - 40 : int'($signed(13'($urandom())));
        case ($urandom_range(0, 9))
            0:       w = 0;
            1:       w = 4096;
            2:       w = $urandom_range(1, 4);
            default: w = $urandom_range(1, 400);
        endcase
        case ($urandom_range(0, 9))
            0:       h = 0;
            1:       h = 4096;
            2:       h = $urandom_range(1, 4);
            default: h = $urandom_range(1, 400);
        endcase
        sel = $urandom_range(0, 9);
        if (sel < 7)      r = $urandom_range(0, ((w < h) ? w : h) / 2);
        else if (sel < 9) r = $urandom_range(0, 2048);
        else              r = 0;
        case ($urandom_range(0, 9))
            0, 1, 2: a = int'(ALPHA_OPAQUE);
            3:       a = int'(ALPHA_CLEAR);
            4:       a = 1;
            5:       a = 254;
            default: a = $urandom_range(0, 255);
        endcase
        apply_setting(x, y, w, h, r, $urandom(), ALPHA_W'(a));
        repeat (count) begin
            if (w > 0 && h > 0 && $urandom_range(0, 99) < 80) begin
                col = $urandom_range(0, ((w > 4096) ? 4096 : w) - 1);
                row = $urandom_range(0, ((h > 4096) ? 4096 : h) - 1);
            end else begin
                col = $urandom_range(0, 4095);
                row = $urandom_range(0, 4095);
            end
            send_pixel(col, row, $urandom());
        end
        settle();
    endtask

    initial begin
        aresetn            = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        s_valid            = 1'b0;
        s_offset_col       = '0;
        s_offset_row       = '0;
        s_background_pixel = '0;
        m_ready            = 1'b0;
        gaps_on            = 1'b1;
        settings_used      = 0;
        idle_cycles        = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: zero-sized rectangle drops everything
        send_pixel(0, 0, 32'hFFFF_FFFF);
        settle();

        // corner circles, all four corners, offsets past the rectangle
        apply_setting(0, 0, 64, 48, 10, 32'hAABB_CCDD, ALPHA_OPAQUE);
        send_pixel(0, 0, 32'h0);
        send_pixel(3, 3, 32'h0);
        send_pixel(63, 0, 32'h0);
        send_pixel(0, 47, 32'h0);
        send_pixel(63, 47, 32'h0);
        send_pixel(60, 44, 32'h0);
        send_pixel(32, 24, 32'h0);
        send_pixel(64, 0, 32'h0);
        send_pixel(0, 48, 32'h0);
        send_pixel(4095, 4095, 32'hFFFF_FFFF);
        settle();

        // half blend, right and bottom screen edges
        apply_setting(1020, 760, 4096, 4096, 0, 32'h00FF_8000, 8'd128);
        send_pixel(0, 0, 32'hFFFF_FFFF);
        send_pixel(3, 7, 32'h0);
        send_pixel(4, 0, 32'h0);
        send_pixel(0, 8, 32'h0);
        send_pixel(2, 5, 32'h1234_5678);
        settle();

        // most negative origin, radius 2048, transparent
        apply_setting(-4096, -4096, 4096, 4096, 2048, 32'hFFFF_FFFF, ALPHA_CLEAR);
        send_pixel(4095, 4095, 32'hFFFF_FFFF);
        send_pixel(0, 0, 32'h0);
        settle();

        // overlapping corner regions, minimal alpha
        apply_setting(-5, -3, 10, 10, 7, 32'h0, 8'd1);
        send_pixel(5, 5, 32'hFFFF_FFFF);
        send_pixel(9, 9, 32'hFFFF_FFFF);
        send_pixel(6, 0, 32'hFFFF_FFFF);
        send_pixel(9, 1, 32'hFFFF_FFFF);
        settle();

        apply_setting(4095, 4095, 1, 1, 0, 32'h8080_8080, 8'd254);
        send_pixel(0, 0, 32'h7F7F_7F7F);
        settle();
        apply_setting(1023, 767, 1, 1, 0, 32'h8080_8080, 8'd254);
        send_pixel(0, 0, 32'h7F7F_7F7F);
        settle();

        for (int phase = 0; phase < 6; phase++) begin
            gaps_on <= (phase != 3);
            run_random_phase(75);
        end
        gaps_on <= 1'b1;
        settle();

        $display("Checked %0d pixel results (%0d writes) across %0d fill settings.",
                 results_checked, pixels_written, settings_used);
        $display("Covered corner circles, screen clipping, opaque, blended and clear fills.");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/rraf_pkg.sv
rtl/rraf_blend.sv
rtl/rounded_rect_alpha_fill_top.sv
dv/rraf_fill_checker.sv
dv/rounded_rect_alpha_fill_top_tb.sv
